### design/lfit_pkg.sv
// Shared types and constants for the line framer with idle timeout.
`timescale 1ns / 1ps

package lfit_pkg;

  // Line store depth and derived index width
  localparam int BUF_BYTES = 64;
  localparam int IDX_W     = $clog2(BUF_BYTES);

  // Fixed field widths
  localparam int CMD_W   = 2;
  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 6;
  localparam int TIMER_W = 16;

  localparam logic [TIMER_W-1:0] TIMER_MAX       = '1;
  localparam logic [TIMER_W-1:0] IDLE_LIMIT_RST  = TIMER_W'(50);
  localparam logic [BYTE_W-1:0]  CH_CR           = 8'h0D;
  localparam logic [BYTE_W-1:0]  CH_LF           = 8'h0A;

  // Input commands
  typedef enum logic [CMD_W-1:0] {
    CMD_BYTE = 2'd0,
    CMD_TICK = 2'd1,
    CMD_TAKE = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  // Input beat
  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] byte_value;
  } in_beat_t;

  // Output beat
  typedef struct packed {
    logic [BYTE_W-1:0] packet_byte;
    logic              last;
    logic [LEN_W-1:0]  packet_length;
    logic              ended_by_delimiter;
  } out_beat_t;

endpackage

### design/lfit_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module lfit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port: data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/line_framer_idle_timeout.sv
// Top level of the line framer: command decode, counters, emit sequencer.
`timescale 1ns / 1ps

// Receive, tick and take beats that do not close a packet are taken without
// stalling the input. A beat that closes a packet keeps the input stalled
// while the run, for each byte, reads the line store (ST_RD) and then loads
// the output register (ST_LD), waiting there while the output side stalls. The
// output register lets the last byte of a run wait while the next input beat
// is taken. The line store is written at one address per kept data byte and
// read back only during a later run, so no forwarding is needed. The idle limit
// register is written through the config channel, which is always ready.

module line_framer_idle_timeout (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lfit_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lfit_pkg::out_beat_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [15:0]         cfg_data_i
);

  import lfit_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_LD
  } state_e;

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   fill_q, fill_d;
  logic [TIMER_W-1:0] timer_q, timer_d;
  logic               pending_q, pending_d;
  logic [TIMER_W-1:0] limit_q;
  logic [IDX_W-1:0]   len_q, len_d;
  logic               delim_q, delim_d;
  logic [IDX_W-1:0]   rd_idx_q, rd_idx_d;
  logic               out_valid_q, out_valid_d;
  out_beat_t          out_q, out_d;

  logic               in_acc;
  logic               is_delim;
  logic               mem_we;
  logic               mem_re;
  logic [BYTE_W-1:0]  mem_rdata;
  logic [TIMER_W-1:0] timer_inc;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign is_delim = (in_data_i.byte_value == CH_CR) || (in_data_i.byte_value == CH_LF);
  assign timer_inc = (timer_q < TIMER_MAX) ? timer_q + 1'b1 : timer_q;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Store the byte at the current fill position
  assign mem_we = in_acc && (cmd_e'(in_data_i.command) == CMD_BYTE) && !is_delim
                  && (fill_q < IDX_W'(BUF_BYTES - 1));
  assign mem_re = (state_q == ST_RD);

  lfit_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUF_BYTES)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (fill_q),
    .wdata_i (in_data_i.byte_value),
    .re_i    (mem_re),
    .raddr_i (rd_idx_q),
    .rdata_o (mem_rdata)
  );

  // Decode commands and sequence the packet run
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    timer_d     = timer_q;
    pending_d   = pending_q;
    len_d       = len_q;
    delim_d     = delim_q;
    rd_idx_d    = rd_idx_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    // Drop the output beat once taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (cmd_e'(in_data_i.command))
            CMD_BYTE: begin
              timer_d = '0;
              if (is_delim) begin
                if (fill_q != '0) begin
                  len_d     = fill_q;
                  delim_d   = 1'b1;
                  fill_d    = '0;
                  pending_d = 1'b1;
                  rd_idx_d  = '0;
                  state_d   = ST_RD;
                end
              end else if (fill_q < IDX_W'(BUF_BYTES - 1)) begin
                fill_d = fill_q + 1'b1;
              end else begin
                // Overflow: drop the byte and close undelimited
                len_d     = IDX_W'(BUF_BYTES - 1);
                delim_d   = 1'b0;
                fill_d    = '0;
                pending_d = 1'b1;
                rd_idx_d  = '0;
                state_d   = ST_RD;
              end
            end
            CMD_TICK: begin
              timer_d = timer_inc;
              if (!pending_q && (fill_q != '0) && (timer_inc > limit_q)) begin
                len_d     = fill_q;
                delim_d   = 1'b0;
                fill_d    = '0;
                pending_d = 1'b1;
                rd_idx_d  = '0;
                state_d   = ST_RD;
              end
            end
            CMD_TAKE: begin
              pending_d = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_RD: begin
        state_d = ST_LD;
      end
      ST_LD: begin
        // Load the read byte once the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d                  = 1'b1;
          out_d.packet_byte            = mem_rdata;
          out_d.last                   = (rd_idx_q == len_q - 1'b1);
          out_d.packet_length          = LEN_W'(len_q);
          out_d.ended_by_delimiter     = delim_q;
          if (rd_idx_q == len_q - 1'b1) begin
            state_d = ST_IDLE;
          end else begin
            rd_idx_d = rd_idx_q + 1'b1;
            state_d  = ST_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      timer_q     <= '0;
      pending_q   <= 1'b0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      timer_q     <= timer_d;
      pending_q   <= pending_d;
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    len_q   <= len_d;
    delim_q <= delim_d;
    out_q   <= out_d;
  end

  // Idle limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= IDLE_LIMIT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= cfg_data_i;
    end
  end

  // Fill count never passes the last usable entry
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= IDX_W'(BUF_BYTES - 1))
    else $error("fill count out of range");

  // A run always starts with the pending flag set and the fill count cleared
  a_run_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD && rd_idx_q == '0) |-> (pending_q && fill_q == '0))
    else $error("run started without pending flag");

  // A run never walks past its length
  a_run_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (rd_idx_q < len_q))
    else $error("read index beyond packet length");

endmodule
